// ----- sv/modbus_rtu_slave_frame_engine_top_macros.svh -----
// Assertion helpers for the frame engine checker.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_TOP_MACROS_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define MRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define MRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mrs_pkg.sv -----
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int FRAME_DEPTH_DEF   = 64;
  localparam int MAX_READ_REGS_DEF = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FN_READ_HOLD  = 8'h03;
  localparam logic [7:0] FN_READ_INPUT = 8'h04;
  localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FN_WRITE_MANY = 8'h10;

  localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;

  typedef enum logic [2:0] {
    ST_RX,
    ST_CHECK,
    ST_RD_HI,
    ST_RD_LO,
    ST_WR,
    ST_TX
  } state_t;

  typedef struct packed {
    logic [7:0] fan1;
    logic [7:0] fan2;
    logic [7:0] level;
    logic [7:0] channel;
    logic [7:0] sync;
    logic [7:0] mode;
    logic [7:0] alarm;
    logic [7:0] master;
  } hold_t;

  // Fold one byte into a reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] v;
    v = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ----- sv/mrs_crc.sv -----
`timescale 1ns / 1ps
module mrs_crc import mrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        init,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (init) begin
      crc_nxt = CRC_INIT;
    end else if (en) begin
      crc_nxt = crc_byte(crc_r, data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ----- sv/modbus_rtu_slave_frame_engine_top.sv -----
`timescale 1ns / 1ps
// Sequence: after the frame end item the engine checks the frame, runs the store
//   write-back for function 16, then sends one reply item per cycle unless out_stall holds it.
// Throughput: one received item per cycle while collecting; the frame store
//   read port paces function 16 through ST_RD_HI, ST_RD_LO and ST_WR per register written.
// Reset: synchronous, active low; clears frame count, holding registers, CRCs.
module modbus_rtu_slave_frame_engine_top import mrs_pkg::*; #(
  parameter int FRAME_DEPTH   = FRAME_DEPTH_DEF,
  parameter int MAX_READ_REGS = MAX_READ_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_slave_address,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  input  logic [7:0]  in_ntc_temp,
  input  logic [7:0]  in_ambient_humidity,
  input  logic [7:0]  in_ambient_temp,
  input  logic [7:0]  in_run_minutes,
  input  logic [15:0] in_run_hours,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic [7:0]  out_fan1_speed,
  output logic [7:0]  out_fan2_speed,
  output logic [7:0]  out_mains_level,
  output logic [7:0]  out_mains_channels,
  output logic [7:0]  out_sync_enable,
  output logic [7:0]  out_work_mode,
  output logic [7:0]  out_alarm_temp,
  output logic [7:0]  out_master_switch
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int LW = $clog2(5 + 2 * MAX_READ_REGS + 1);

  // Frame store: one write port fed by the receive side, one read port.
  logic [7:0] mem [FRAME_DEPTH];
  logic [7:0] rdata_r;
  logic [AW-1:0] raddr;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    hdr_r [8];
  logic [7:0]    addr_r;
  logic [7:0]    ntc_r, hum_r, amb_r, min_r;
  logic [15:0]   hrs_r;
  hold_t         hold_r, hold_nxt;
  logic [LW-1:0] idx_r, idx_nxt, len_r, len_nxt;
  logic [7:0]    k_r, k_nxt;
  logic [7:0]    hi_r;

  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  hold_t         out_hold_r, out_hold_nxt;

  logic        in_acc, store_en, load;
  logic [15:0] rx_crc, tx_crc;
  logic        tx_crc_init, tx_crc_en;

  logic [7:0]  fn;
  logic [15:0] start, qty;
  logic        base_ok, rd_ok, w1_ok, wm_ok;
  logic        wr_en, wr_sw;
  logic [16:0] wr_addr;
  logic [7:0]  wr_hi, wr_lo;
  logic [7:0]  tx_gen;
  logic [7:0]  j;
  logic [16:0] rd_reg;
  logic [15:0] rd_val;

  function automatic logic [15:0] read_hold(input hold_t h, input logic [16:0] a);
    logic [15:0] v;
    case (a)
      17'd0:   v = {8'h00, h.fan1};
      17'd1:   v = {8'h00, h.fan2};
      17'd2:   v = {h.level, h.channel};
      17'd3:   v = {8'h00, h.sync};
      17'd4:   v = {8'h00, h.mode};
      17'd5:   v = {8'h00, h.alarm};
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic hold_t write_hold(input hold_t h, input logic [16:0] a,
                                       input logic [7:0] hi, input logic [7:0] lo,
                                       input logic sw);
    hold_t r;
    r = h;
    case (a)
      17'd0: r.fan1 = lo;
      17'd1: r.fan2 = lo;
      17'd2: begin
        r.level   = hi;
        r.channel = lo;
      end
      17'd3: r.sync  = lo;
      17'd4: r.mode  = lo;
      17'd5: r.alarm = lo;
      17'd6: if (sw) r.master = lo;
      default: r = h;
    endcase
    return r;
  endfunction

  // Take received items only while collecting.
  assign in_stall = (state_r != ST_RX);
  assign in_acc   = in_valid && !in_stall;
  assign store_en = in_acc && (cnt_r < CW'(FRAME_DEPTH));
  assign load     = (state_r == ST_TX) && (!out_valid_r || !out_stall);

  // Receive CRC runs over every stored byte, CRC included: a good frame leaves zero.
  mrs_crc u_rx_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (state_r == ST_CHECK),
    .en    (store_en),
    .data  (in_rx_byte),
    .crc   (rx_crc)
  );

  // Reply CRC folds each reply byte as it is loaded, ahead of the CRC bytes.
  mrs_crc u_tx_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (tx_crc_init),
    .en    (tx_crc_en),
    .data  (tx_gen),
    .crc   (tx_crc)
  );

  assign fn    = hdr_r[1];
  assign start = {hdr_r[2], hdr_r[3]};
  assign qty   = {hdr_r[4], hdr_r[5]};

  always_comb begin
    base_ok = !ovf_r && (cnt_r >= CW'(4)) && (rx_crc == 16'h0000) && (hdr_r[0] == addr_r);
    rd_ok   = base_ok && ((fn == FN_READ_HOLD) || (fn == FN_READ_INPUT))
              && (cnt_r == CW'(8)) && (qty != 16'd0) && (qty <= 16'(MAX_READ_REGS));
    w1_ok   = base_ok && (fn == FN_WRITE_ONE) && (cnt_r == CW'(8));
    wm_ok   = base_ok && (fn == FN_WRITE_MANY) && (cnt_r >= CW'(9)) && (hdr_r[6] >= 8'd2)
              && (10'(cnt_r) == 10'd9 + 10'(hdr_r[6]));
  end

  // Reply byte for the current index.
  always_comb begin
    j      = 8'(idx_r) - 8'd3;
    rd_reg = 17'(start) + 17'(j[7:1]);
    if (fn == FN_READ_HOLD) begin
      rd_val = read_hold(hold_r, rd_reg);
    end else begin
      case (rd_reg)
        17'd0:   rd_val = {8'h00, ntc_r};
        17'd1:   rd_val = {hum_r, amb_r};
        17'd2:   rd_val = {8'h00, min_r};
        17'd3:   rd_val = hrs_r;
        default: rd_val = 16'h0000;
      endcase
    end
    if ((fn == FN_WRITE_ONE) || ((fn == FN_WRITE_MANY) && (idx_r < LW'(6)))) begin
      tx_gen = hdr_r[idx_r[2:0]];
    end else if (idx_r == len_r - LW'(2)) begin
      tx_gen = tx_crc[7:0];
    end else if (idx_r == len_r - LW'(1)) begin
      tx_gen = tx_crc[15:8];
    end else if (fn == FN_WRITE_MANY) begin
      tx_gen = tx_crc[7:0];
    end else if (idx_r == LW'(0)) begin
      tx_gen = hdr_r[0];
    end else if (idx_r == LW'(1)) begin
      tx_gen = fn;
    end else if (idx_r == LW'(2)) begin
      tx_gen = {qty[6:0], 1'b0};
    end else begin
      tx_gen = j[0] ? rd_val[7:0] : rd_val[15:8];
    end
  end

  assign tx_crc_en = load && (idx_r < len_r - LW'(2));

  always_comb begin
    unique case (state_r)
      ST_RD_HI: raddr = AW'(9'd7 + {k_r, 1'b0});
      default:  raddr = AW'(9'd8 + {k_r, 1'b0});
    endcase
  end

  // Sequencer: collect, check, write back from the store for function 16, then stream the reply.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    tx_crc_init   = 1'b0;
    wr_en         = 1'b0;
    wr_sw         = 1'b0;
    wr_addr       = 17'(start);
    wr_hi         = hdr_r[4];
    wr_lo         = hdr_r[5];
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_hold_nxt  = out_hold_r;
    unique case (state_r)
      ST_RX: begin
        if (in_acc) begin
          if (store_en) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_frame_end) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cnt_nxt     = '0;
        ovf_nxt     = 1'b0;
        idx_nxt     = '0;
        k_nxt       = '0;
        tx_crc_init = 1'b1;
        len_nxt     = LW'(8);
        if (rd_ok) begin
          len_nxt   = LW'(17'd5 + {qty, 1'b0});
          state_nxt = ST_TX;
        end else if (w1_ok) begin
          wr_en     = 1'b1;
          wr_sw     = 1'b1;
          state_nxt = ST_TX;
        end else if (wm_ok) begin
          state_nxt = ST_RD_HI;
        end else begin
          state_nxt = ST_RX;
        end
      end
      ST_RD_HI: state_nxt = ST_RD_LO;
      ST_RD_LO: state_nxt = ST_WR;
      ST_WR: begin
        wr_en   = 1'b1;
        wr_addr = 17'(start) + 17'(k_r);
        wr_hi   = hi_r;
        wr_lo   = rdata_r;
        k_nxt   = k_r + 8'd1;
        if (k_nxt == {1'b0, hdr_r[6][7:1]}) begin
          state_nxt = ST_TX;
        end else begin
          state_nxt = ST_RD_HI;
        end
      end
      ST_TX: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = tx_gen;
          out_last_nxt  = (idx_r == len_r - LW'(1));
          out_hold_nxt  = hold_r;
          idx_nxt       = idx_r + LW'(1);
          if (out_last_nxt) begin
            state_nxt = ST_RX;
          end
        end
      end
      default: state_nxt = ST_RX;
    endcase
    hold_nxt = wr_en ? write_hold(hold_r, wr_addr, wr_hi, wr_lo, wr_sw) : hold_r;
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[cnt_r[AW-1:0]] <= in_rx_byte;
    end
    rdata_r <= mem[raddr];
  end

  // Header bytes and live sensor values; no reset needed.
  always_ff @(posedge clk) begin
    if (store_en && (cnt_r < CW'(8))) begin
      hdr_r[cnt_r[2:0]] <= in_rx_byte;
    end
    if (in_acc) begin
      ntc_r <= in_ntc_temp;
      hum_r <= in_ambient_humidity;
      amb_r <= in_ambient_temp;
      min_r <= in_run_minutes;
      hrs_r <= in_run_hours;
    end
    if (state_r == ST_RD_LO) begin
      hi_r <= rdata_r;
    end
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_hold_r <= out_hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RX;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      hold_r      <= '0;
      addr_r      <= SLAVE_ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        addr_r <= cfg_slave_address;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_byte        = out_byte_r;
  assign out_tx_last        = out_last_r;
  assign out_fan1_speed     = out_hold_r.fan1;
  assign out_fan2_speed     = out_hold_r.fan2;
  assign out_mains_level    = out_hold_r.level;
  assign out_mains_channels = out_hold_r.channel;
  assign out_sync_enable    = out_hold_r.sync;
  assign out_work_mode      = out_hold_r.mode;
  assign out_alarm_temp     = out_hold_r.alarm;
  assign out_master_switch  = out_hold_r.master;

endmodule

// ----- sv/mrs_checker.sv -----
`timescale 1ns / 1ps
`include "modbus_rtu_slave_frame_engine_top_macros.svh"
module mrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_tx_last,
  input logic [7:0] out_tx_byte,
  input logic       in_stall
);

  `MRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "reply item dropped")
  `MRS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_tx_byte), "reply item changed")
  `MRS_ASSERT_NEXT(a_gap_after_last, out_valid && !out_stall && out_tx_last, !out_valid,
                   "reply item after last")
  `MRS_ASSERT_NOW(a_busy_mid_reply, out_valid && !out_tx_last, in_stall,
                  "receive open mid reply")

endmodule

bind modbus_rtu_slave_frame_engine_top mrs_checker u_mrs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_tx_last (out_tx_last),
  .out_tx_byte (out_tx_byte),
  .in_stall    (in_stall)
);

// ----- bench/tb_modbus_rtu_slave_frame_engine_top.sv -----
`timescale 1ns / 1ps
module tb_modbus_rtu_slave_frame_engine_top;
  import mrs_pkg::*;

  // Clock and reset.
  logic clk;
  logic rst_n;

  // Configuration port.
  logic       cfg_we;
  logic [7:0] cfg_slave_address;

  // Received-byte channel.
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        in_frame_end;
  logic [7:0]  in_ntc_temp;
  logic [7:0]  in_ambient_humidity;
  logic [7:0]  in_ambient_temp;
  logic [7:0]  in_run_minutes;
  logic [15:0] in_run_hours;

  // Response-byte channel.
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_tx_byte;
  logic       out_tx_last;
  logic [7:0] out_fan1_speed;
  logic [7:0] out_fan2_speed;
  logic [7:0] out_mains_level;
  logic [7:0] out_mains_channels;
  logic [7:0] out_sync_enable;
  logic [7:0] out_work_mode;
  logic [7:0] out_alarm_temp;
  logic [7:0] out_master_switch;

  // One expected response byte, with the register outputs that go with it.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [7:0] fan1;
    logic [7:0] fan2;
    logic [7:0] level;
    logic [7:0] channel;
    logic [7:0] sync;
    logic [7:0] mode;
    logic [7:0] alarm;
    logic [7:0] master;
  } reply_byte_t;

  localparam int FRAME_DEPTH = FRAME_DEPTH_DEF;
  localparam int MAX_READ    = MAX_READ_REGS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;

  // Shadow copy of the slave's state, kept by the predictor.
  logic [7:0] shadow_addr;
  logic [7:0] shadow_frame [FRAME_DEPTH];
  int         shadow_count;
  logic       shadow_overflow;
  logic [7:0] sh_fan1, sh_fan2, sh_level, sh_channel;
  logic [7:0] sh_sync, sh_mode, sh_alarm, sh_master;

  // Response bytes expected and not yet seen.
  reply_byte_t pending_replies [$];

  int  mismatches;
  int  cycles;
  bit  idle_free;

  // Sensor values sent with the next received byte.
  logic [7:0]  sens_ntc, sens_hum, sens_amb, sens_min;
  logic [15:0] sens_hours;

  modbus_rtu_slave_frame_engine_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_slave_address   (cfg_slave_address),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .in_frame_end        (in_frame_end),
    .in_ntc_temp         (in_ntc_temp),
    .in_ambient_humidity (in_ambient_humidity),
    .in_ambient_temp     (in_ambient_temp),
    .in_run_minutes      (in_run_minutes),
    .in_run_hours        (in_run_hours),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tx_byte         (out_tx_byte),
    .out_tx_last         (out_tx_last),
    .out_fan1_speed      (out_fan1_speed),
    .out_fan2_speed      (out_fan2_speed),
    .out_mains_level     (out_mains_level),
    .out_mains_channels  (out_mains_channels),
    .out_sync_enable     (out_sync_enable),
    .out_work_mode       (out_work_mode),
    .out_alarm_temp      (out_alarm_temp),
    .out_master_switch   (out_master_switch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard the run against a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Reflected CRC-16 over a byte queue, init all ones.
  function automatic logic [15:0] modbus_crc(input logic [7:0] data [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (data[k]) begin
      c = c ^ {8'h00, data[k]};
      for (int b = 0; b < 8; b++) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] holding_value(input int unsigned a);
    case (a)
      0: return {8'h00, sh_fan1};
      1: return {8'h00, sh_fan2};
      2: return {sh_level, sh_channel};
      3: return {8'h00, sh_sync};
      4: return {8'h00, sh_mode};
      5: return {8'h00, sh_alarm};
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] sensor_value(input int unsigned a, input logic [7:0] ntc,
                                               input logic [7:0] hum, input logic [7:0] amb,
                                               input logic [7:0] mins, input logic [15:0] hrs);
    case (a)
      0: return {8'h00, ntc};
      1: return {hum, amb};
      2: return {8'h00, mins};
      3: return hrs;
      default: return 16'h0000;
    endcase
  endfunction

  // Apply one register write; register 6 only from the single-write function.
  task automatic store_register(input int unsigned a, input logic [7:0] hi,
                                input logic [7:0] lo, input bit switch_ok);
    case (a)
      0: sh_fan1 = lo;
      1: sh_fan2 = lo;
      2: begin
        sh_level = hi;
        sh_channel = lo;
      end
      3: sh_sync = lo;
      4: sh_mode = lo;
      5: sh_alarm = lo;
      6: if (switch_ok) sh_master = lo;
      default: ;
    endcase
  endtask

  // Build the reply to the frame now held in the shadow store.
  task automatic build_reply(input logic [7:0] ntc, input logic [7:0] hum,
                             input logic [7:0] amb, input logic [7:0] mins,
                             input logic [15:0] hrs, output logic [7:0] reply [$]);
    logic [7:0]  body [$];
    logic [7:0]  fn;
    logic [15:0] crc;
    int unsigned n, start, qty, bc;
    logic [15:0] v;
    reply = {};
    n = shadow_count;
    if (shadow_overflow || n < 4) return;
    body = {};
    for (int k = 0; k < n - 2; k++) body.push_back(shadow_frame[k]);
    crc = modbus_crc(body);
    if ({shadow_frame[n - 1], shadow_frame[n - 2]} != crc) return;
    if (shadow_frame[0] != shadow_addr) return;
    fn = shadow_frame[1];
    start = 32'({shadow_frame[2], shadow_frame[3]});
    if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
      if (n != 8) return;
      qty = 32'({shadow_frame[4], shadow_frame[5]});
      if (qty == 0 || qty > MAX_READ) return;
      reply.push_back(shadow_addr);
      reply.push_back(fn);
      reply.push_back(8'(qty * 2));
      for (int unsigned k = 0; k < qty; k++) begin
        if (fn == FN_READ_HOLD) v = holding_value(start + k);
        else v = sensor_value(start + k, ntc, hum, amb, mins, hrs);
        reply.push_back(v[15:8]);
        reply.push_back(v[7:0]);
      end
      crc = modbus_crc(reply);
      reply.push_back(crc[7:0]);
      reply.push_back(crc[15:8]);
    end else if (fn == FN_WRITE_ONE) begin
      if (n != 8) return;
      store_register(start, shadow_frame[4], shadow_frame[5], 1'b1);
      for (int k = 0; k < 8; k++) reply.push_back(shadow_frame[k]);
    end else if (fn == FN_WRITE_MANY) begin
      if (n < 9) return;
      bc = 32'(shadow_frame[6]);
      if (bc < 2 || n != 9 + bc) return;
      for (int unsigned k = 0; k < bc / 2; k++)
        store_register(start + k, shadow_frame[7 + 2 * k], shadow_frame[8 + 2 * k], 1'b0);
      for (int k = 0; k < 6; k++) reply.push_back(shadow_frame[k]);
      crc = modbus_crc(reply);
      reply.push_back(crc[7:0]);
      reply.push_back(crc[15:8]);
    end
  endtask

  // Take in one accepted byte and queue whatever reply it completes.
  task automatic predict_item(input logic [7:0] rx, input logic fend,
                              input logic [7:0] ntc, input logic [7:0] hum,
                              input logic [7:0] amb, input logic [7:0] mins,
                              input logic [15:0] hrs);
    logic [7:0]  reply [$];
    reply_byte_t rb;
    if (shadow_count < FRAME_DEPTH) begin
      shadow_frame[shadow_count] = rx;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (!fend) return;
    build_reply(ntc, hum, amb, mins, hrs, reply);
    shadow_count = 0;
    shadow_overflow = 1'b0;
    foreach (reply[k]) begin
      rb.tx_byte = reply[k];
      rb.tx_last = (k == reply.size() - 1);
      rb.fan1    = sh_fan1;
      rb.fan2    = sh_fan2;
      rb.level   = sh_level;
      rb.channel = sh_channel;
      rb.sync    = sh_sync;
      rb.mode    = sh_mode;
      rb.alarm   = sh_alarm;
      rb.master  = sh_master;
      pending_replies.push_back(rb);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic bit take_gap();
    return !idle_free && ($urandom_range(0, 99) < 21);
  endfunction

  // Offer one byte and hold it until the slave takes it; valid stays up after,
  // so the next byte can follow at once.
  task automatic send_byte(input logic [7:0] rx, input logic fend);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_rx_byte          <= rx;
    in_frame_end        <= fend;
    in_ntc_temp         <= sens_ntc;
    in_ambient_humidity <= sens_hum;
    in_ambient_temp     <= sens_amb;
    in_run_minutes      <= sens_min;
    in_run_hours        <= sens_hours;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(rx, fend, sens_ntc, sens_hum, sens_amb, sens_min, sens_hours);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] frame [$]);
    foreach (frame[k]) send_byte(frame[k], k == frame.size() - 1);
  endtask

  // Append the CRC low byte first.
  task automatic seal_frame(inout logic [7:0] frame [$]);
    logic [15:0] crc;
    crc = modbus_crc(frame);
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
  endtask

  task automatic scramble_sensors();
    sens_ntc   = 8'($urandom);
    sens_hum   = 8'($urandom);
    sens_amb   = 8'($urandom);
    sens_min   = 8'($urandom);
    sens_hours = 16'($urandom);
  endtask

  // Drop valid, wait for every reply byte, then let the slave settle.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Write the slave address; only ever called with the slave idle.
  task automatic set_address(input logic [7:0] a);
    drain_replies();
    cfg_we            <= 1'b1;
    cfg_slave_address <= a;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_addr = a;
  endtask

  // Receiver stall, random with a calm stretch when idle_free is set.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= take_gap();
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    reply_byte_t want;
    reply_byte_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_tx_byte, out_tx_last, out_fan1_speed, out_fan2_speed, out_mains_level,
             out_mains_channels, out_sync_enable, out_work_mode, out_alarm_temp,
             out_master_switch};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply byte %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame builders
  // ---------------------------------------------------------------------------

  task automatic make_read(input logic [7:0] addr, input logic [7:0] fn,
                           input logic [15:0] start, input logic [15:0] qty,
                           output logic [7:0] frame [$]);
    frame = {addr, fn, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    seal_frame(frame);
  endtask

  task automatic make_write_one(input logic [7:0] addr, input logic [15:0] reg_addr,
                                input logic [15:0] value, output logic [7:0] frame [$]);
    frame = {addr, FN_WRITE_ONE, reg_addr[15:8], reg_addr[7:0], value[15:8], value[7:0]};
    seal_frame(frame);
  endtask

  task automatic make_write_many(input logic [7:0] addr, input logic [15:0] start,
                                 input int bc, output logic [7:0] frame [$]);
    logic [15:0] qty;
    qty = 16'(bc / 2);
    frame = {addr, FN_WRITE_MANY, start[15:8], start[7:0], qty[15:8], qty[7:0], 8'(bc)};
    for (int k = 0; k < bc; k++) frame.push_back(8'($urandom));
    seal_frame(frame);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every function at the reset address, with field extremes; the input read runs twice.
  task automatic test_functions();
    logic [7:0] f [$];
    sens_ntc = 8'hFF; sens_hum = 8'h00; sens_amb = 8'hFF; sens_min = 8'h00;
    sens_hours = 16'hFFFF;
    make_write_one(8'h01, 16'd6, 16'hFFFF, f);
    send_frame(f);
    // Odd byte count over registers 1 to 6: trailing byte ignored, register 6 skipped.
    make_write_many(8'h01, 16'd1, 13, f);
    send_frame(f);
    make_read(8'h01, FN_READ_HOLD, 16'd0, 16'd7, f);
    send_frame(f);
    make_read(8'h01, FN_READ_INPUT, 16'd0, 16'(MAX_READ), f);
    send_frame(f);
    sens_ntc = 8'h00; sens_hum = 8'hFF; sens_amb = 8'h00; sens_min = 8'hFF;
    sens_hours = 16'h0000;
    make_read(8'h01, FN_READ_INPUT, 16'hFFFF, 16'd1, f);
    send_frame(f);
  endtask

  // Frames that must get no reply.
  task automatic test_rejects();
    logic [7:0] f [$];
    make_read(8'h01, FN_READ_HOLD, 16'd0, 16'd2, f);
    f[7] = f[7] ^ 8'h01;                          // bad CRC
    send_frame(f);
    make_read(8'h00, FN_READ_HOLD, 16'd0, 16'd2, f);   // broadcast
    send_frame(f);
    make_read(8'h01, 8'h07, 16'd0, 16'd2, f);           // unknown function
    send_frame(f);
    make_read(8'h01, FN_READ_HOLD, 16'd0, 16'd0, f);   // zero quantity
    send_frame(f);
    make_read(8'h01, FN_READ_INPUT, 16'd0, 16'(MAX_READ + 1), f);  // too many
    send_frame(f);
    f = {8'h01, 8'hFF, 8'h00};                            // runt frame
    send_frame(f);
    make_write_many(8'h01, 16'd0, 1, f);                  // byte count below 2
    send_frame(f);
    make_write_one(8'h01, 16'd2, 16'hA55A, f);
    f.insert(6, 8'h00);                                   // wrong length
    send_frame(f);
    // Overrun the frame store: everything past the depth is dropped.
    f = {};
    for (int k = 0; k < FRAME_DEPTH + 1; k++) f.push_back(8'($urandom));
    send_frame(f);
  endtask

  // Random frames: mostly valid requests, some corrupt, some noise.
  task automatic test_random_frames(input int item_budget);
    logic [7:0]  f [$];
    logic [7:0]  addr;
    logic [15:0] start;
    int sent;
    int pick;
    sent = 0;
    while (sent < item_budget) begin
      scramble_sensors();
      addr  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : shadow_addr;
      start = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      pick  = $urandom_range(0, 9);
      case (pick)
        0, 1: make_read(addr, FN_READ_HOLD, start, 16'($urandom_range(1, 8)), f);
        2, 3: make_read(addr, FN_READ_INPUT, start, 16'($urandom_range(1, 6)), f);
        4, 5: make_write_one(addr, start, 16'($urandom), f);
        6:    make_write_many(addr, start, $urandom_range(2, 9), f);
        7:    make_read(addr, 8'($urandom), start, 16'($urandom_range(0, 20)), f);
        default: begin
          f = {};
          repeat ($urandom_range(1, 10)) f.push_back(8'($urandom));
        end
      endcase
      if ($urandom_range(0, 11) == 0) f[$urandom_range(0, f.size() - 1)] ^= 8'($urandom_range(1, 255));
      send_frame(f);
      sent += f.size();
    end
  endtask

  // Move the address to 247, then to 37; the slave must follow each setting.
  task automatic test_addresses();
    logic [7:0] f [$];
    logic [7:0] settings [2];
    settings = '{8'd247, 8'd37};
    foreach (settings[k]) begin
      set_address(settings[k]);
      make_read(settings[k], FN_READ_HOLD, 16'd0, 16'd3, f);
      send_frame(f);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_slave_address = SLAVE_ADDR_RESET;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    in_frame_end = 1'b0;
    in_ntc_temp = 8'h00;
    in_ambient_humidity = 8'h00;
    in_ambient_temp = 8'h00;
    in_run_minutes = 8'h00;
    in_run_hours = 16'h0000;
    out_stall = 1'b0;
    mismatches = 0;
    cycles = 0;
    idle_free = 1'b0;
    sens_ntc = 8'h00; sens_hum = 8'h00; sens_amb = 8'h00; sens_min = 8'h00;
    sens_hours = 16'h0000;
    shadow_addr = SLAVE_ADDR_RESET;
    shadow_count = 0;
    shadow_overflow = 1'b0;
    {sh_fan1, sh_fan2, sh_level, sh_channel} = '0;
    {sh_sync, sh_mode, sh_alarm, sh_master} = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_functions();
    test_rejects();
    // Hold off until the slave has answered everything, then run without idling.
    drain_replies();
    idle_free = 1'b1;
    test_random_frames(16);
    idle_free = 1'b0;
    test_addresses();
    drain_replies();

    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
